[src/els_pkg.sv]
// ----------------------------------------------------------------------------
// els_pkg
// Shared types and codes for the elevator disk request scheduler.
// ----------------------------------------------------------------------------
package els_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LBA_W           = 24;
    localparam int TAG_W           = 8;

    typedef logic [LBA_W-1:0] lba_t;
    typedef logic [TAG_W-1:0] tag_t;

    // one stored request
    typedef struct packed {
        lba_t lba;
        tag_t tag;
    } entry_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_TAKE   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        status_t status;
        lba_t    lba;
        tag_t    tag;
        logic    going_up;
    } result_t;

endpackage

[src/els_mem.sv]
// ----------------------------------------------------------------------------
// els_mem
// Request store for both lists: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module els_mem #(
    parameter int ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  els_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output els_pkg::entry_t       rd_data
);

    els_pkg::entry_t mem [(1 << ADDR_W)];
    els_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/els_ctrl.sv]
// ----------------------------------------------------------------------------
// els_ctrl
// Sequencer: list bookkeeping, insertion shift loop and pop, with one shared
// address comparator.
// ----------------------------------------------------------------------------
module els_ctrl #(
    parameter int QUEUE_DEPTH = els_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W  = $clog2(QUEUE_DEPTH),
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int ADDR_W = IDX_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  els_pkg::lba_t            request_lba,
    input  els_pkg::tag_t            request_tag,
    output logic                     res_valid,
    input  logic                     res_ready,
    output els_pkg::result_t         res,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output els_pkg::entry_t          mem_wdata,
    output logic                     mem_re,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  els_pkg::entry_t          mem_rdata
);

    localparam int SUM_W = IDX_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_INS_STEP = 6'b000100,
        S_INS_CMP  = 6'b001000,
        S_POP_WAIT = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    // circular index: base + offset, folded back below the depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                state_reg,     state_next;
    els_pkg::cmd_t         cmd_reg,       cmd_next;
    els_pkg::lba_t         lba_reg,       lba_next;
    els_pkg::tag_t         tag_reg,       tag_next;
    logic                  sel_reg,       sel_next;      // 0 up list, 1 down list
    logic [CNT_W-1:0]      pos_reg,       pos_next;
    logic [IDX_W-1:0]      up_head_reg,   up_head_next;
    logic [IDX_W-1:0]      dn_head_reg,   dn_head_next;
    logic [CNT_W-1:0]      up_cnt_reg,    up_cnt_next;
    logic [CNT_W-1:0]      dn_cnt_reg,    dn_cnt_next;
    logic                  sweep_reg,     sweep_next;
    logic                  svc_valid_reg, svc_valid_next;
    els_pkg::lba_t         svc_lba_reg,   svc_lba_next;
    els_pkg::status_t      rs_status_reg, rs_status_next;
    els_pkg::lba_t         rs_lba_reg,    rs_lba_next;
    els_pkg::tag_t         rs_tag_reg,    rs_tag_next;

    logic [IDX_W-1:0]      cur_head;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      tgt_cnt;
    logic [IDX_W-1:0]      phys_pos;
    logic [IDX_W-1:0]      phys_prev;
    els_pkg::lba_t         cmp_x;
    els_pkg::lba_t         cmp_y;
    logic                  cmp_lt;
    logic                  to_down;
    logic                  pick_ok;
    logic                  pick_sel;

    assign cur_head  = sel_reg ? dn_head_reg : up_head_reg;
    assign cur_cnt   = sel_reg ? dn_cnt_reg  : up_cnt_reg;
    assign phys_pos  = wrap_add(cur_head, pos_reg);
    assign phys_prev = wrap_add(cur_head, pos_reg - ONE_C);

    // shared comparator: x < y
    always_comb
    begin
        cmp_x = lba_reg;
        cmp_y = mem_rdata.lba;
        if (state_reg == S_DISPATCH)
        begin
            cmp_y = svc_lba_reg;
        end
        else if (sel_reg)
        begin
            // descending list: new goes first when new > stored
            cmp_x = mem_rdata.lba;
            cmp_y = lba_reg;
        end
    end
    assign cmp_lt = cmp_x < cmp_y;

    assign to_down = svc_valid_reg && cmp_lt;
    assign tgt_cnt = to_down ? dn_cnt_reg : up_cnt_reg;

    // list picked by a take: current direction first, else the other one
    always_comb
    begin
        pick_ok  = 1'b1;
        pick_sel = 1'b0;
        if (sweep_reg)
        begin
            if (up_cnt_reg != '0)
            begin
                pick_sel = 1'b0;
            end
            else if (dn_cnt_reg != '0)
            begin
                pick_sel = 1'b1;
            end
            else
            begin
                pick_ok = 1'b0;
            end
        end
        else
        begin
            if (dn_cnt_reg != '0)
            begin
                pick_sel = 1'b1;
            end
            else if (up_cnt_reg != '0)
            begin
                pick_sel = 1'b0;
            end
            else
            begin
                pick_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lba_next       = lba_reg;
        tag_next       = tag_reg;
        sel_next       = sel_reg;
        pos_next       = pos_reg;
        up_head_next   = up_head_reg;
        dn_head_next   = dn_head_reg;
        up_cnt_next    = up_cnt_reg;
        dn_cnt_next    = dn_cnt_reg;
        sweep_next     = sweep_reg;
        svc_valid_next = svc_valid_reg;
        svc_lba_next   = svc_lba_reg;
        rs_status_next = rs_status_reg;
        rs_lba_next    = rs_lba_reg;
        rs_tag_next    = rs_tag_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {sel_reg, phys_pos};
        mem_wdata      = '{lba: lba_reg, tag: tag_reg};
        mem_re         = 1'b0;
        mem_raddr      = {sel_reg, phys_prev};

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = els_pkg::cmd_t'(command);
                    lba_next   = request_lba;
                    tag_next   = request_tag;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                rs_lba_next = '0;
                rs_tag_next = '0;
                if (cmd_reg == els_pkg::CMD_INSERT)
                begin
                    sel_next = to_down;
                    if (tgt_cnt == DEPTH_C)
                    begin
                        rs_status_next = els_pkg::ST_FULL;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        pos_next   = tgt_cnt;
                        state_next = S_INS_STEP;
                    end
                end
                else if (!pick_ok)
                begin
                    rs_status_next = els_pkg::ST_EMPTY;
                    svc_valid_next = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    sel_next   = pick_sel;
                    sweep_next = !pick_sel;
                    mem_re     = 1'b1;
                    mem_raddr  = {pick_sel, pick_sel ? dn_head_reg : up_head_reg};
                    state_next = S_POP_WAIT;
                end
            end

            S_INS_STEP:
            begin
                if (pos_reg == '0)
                begin
                    mem_we         = 1'b1;
                    rs_status_next = els_pkg::ST_INSERTED;
                    state_next     = S_DONE;
                    if (sel_reg)
                    begin
                        dn_cnt_next = dn_cnt_reg + ONE_C;
                    end
                    else
                    begin
                        up_cnt_next = up_cnt_reg + ONE_C;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    // new request goes ahead of this entry: move it one down
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg - ONE_C;
                    state_next = S_INS_STEP;
                end
                else
                begin
                    rs_status_next = els_pkg::ST_INSERTED;
                    state_next     = S_DONE;
                    if (sel_reg)
                    begin
                        dn_cnt_next = dn_cnt_reg + ONE_C;
                    end
                    else
                    begin
                        up_cnt_next = up_cnt_reg + ONE_C;
                    end
                end
            end

            S_POP_WAIT:
            begin
                rs_status_next = els_pkg::ST_SERVED;
                rs_lba_next    = mem_rdata.lba;
                rs_tag_next    = mem_rdata.tag;
                svc_valid_next = 1'b1;
                svc_lba_next   = mem_rdata.lba;
                if (sel_reg)
                begin
                    dn_head_next = wrap_add(dn_head_reg, ONE_C);
                    dn_cnt_next  = cur_cnt - ONE_C;
                end
                else
                begin
                    up_head_next = wrap_add(up_head_reg, ONE_C);
                    up_cnt_next  = cur_cnt - ONE_C;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = '{status:   rs_status_reg,
                   lba:      rs_lba_reg,
                   tag:      rs_tag_reg,
                   going_up: sweep_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            up_head_reg   <= '0;
            dn_head_reg   <= '0;
            up_cnt_reg    <= '0;
            dn_cnt_reg    <= '0;
            sweep_reg     <= 1'b1;
            svc_valid_reg <= 1'b0;
            svc_lba_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            up_head_reg   <= up_head_next;
            dn_head_reg   <= dn_head_next;
            up_cnt_reg    <= up_cnt_next;
            dn_cnt_reg    <= dn_cnt_next;
            sweep_reg     <= sweep_next;
            svc_valid_reg <= svc_valid_next;
            svc_lba_reg   <= svc_lba_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lba_reg       <= lba_next;
        tag_reg       <= tag_next;
        sel_reg       <= sel_next;
        pos_reg       <= pos_next;
        rs_status_reg <= rs_status_next;
        rs_lba_reg    <= rs_lba_next;
        rs_tag_reg    <= rs_tag_next;
    end

endmodule

[src/elevator_disk_request_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// elevator_disk_request_scheduler_unit
// LOOK elevator scheduler keeping ascending and descending request lists.
// ----------------------------------------------------------------------------
// Sequence (accept to output register): a take-next passes dispatch, a store
//   read and done; with both lists empty, or for a rejected insert, dispatch
//   goes straight to done. An insert reads and shifts k < QUEUE_DEPTH entries
//   one down, then writes. One transaction at a time: none is accepted until the last result leaves the sequencer.
// Reset: asynchronous active low; both lists empty, sweep ascending, nothing
//   in service. The request store itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module elevator_disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = els_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [23:0]          request_lba,
    input  logic [7:0]           request_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [23:0]          served_lba,
    output logic [7:0]           served_tag,
    output logic                 going_up
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH) + 1;

    // store port: up list in the lower half, down list in the upper half,
    // each list a circular buffer kept in sorted order from its head
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    els_pkg::entry_t       mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    els_pkg::entry_t       mem_rdata;

    // sequencer result handshake
    logic                  res_valid;
    logic                  res_ready;
    els_pkg::result_t      res;

    // output register: sequencer can take the next transaction while a
    // result still waits here
    logic                  out_valid_reg;
    els_pkg::result_t      out_data_reg;

    els_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    els_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .request_lba (request_lba),
        .request_tag (request_tag),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_data_reg.status;
    assign served_lba = out_data_reg.lba;
    assign served_tag = out_data_reg.tag;
    assign going_up   = out_data_reg.going_up;

    // busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted back to back");

    // only a served request carries an address and tag
    a_zero_unless_served: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != els_pkg::ST_SERVED)) |->
            ((served_lba == '0) && (served_tag == '0)))
        else $error("nonzero payload on non-served result");

    // no new transaction while the sequencer holds a finished result
    a_no_accept_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("input ready while result pending in sequencer");

endmodule
